>>> rtl/axis_angle_rotation_matrix_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define AAR_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// The consequent must hold in the cycle after the condition.
`define AAR_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> rtl/aar_pkg.sv
// ----------------------------------------------------------------------------
// aar_pkg
// Shared widths, fixed-point constants, the CORDIC arctangent table and the
// payload types of the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package aar_pkg;

    // Field widths of the beats.
    localparam int AXIS_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int CELL_W      = 16;

    // CORDIC datapath width, Q.30 with headroom for angles up to 4 radians.
    localparam int CW          = 34;
    // The Q3.13 angle is widened to Q.30 by this shift.
    localparam int ANGLE_SHIFT = 17;
    // Number of tabulated arctangent entries, and the default stage count.
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STAGES = 16;

    // Axis times a CORDIC value, and the exact Q.58 accumulation width.
    localparam int PW          = AXIS_W + CW;
    localparam int SW          = 64;
    localparam int C_SHIFT     = 28;
    localparam int S_SHIFT     = 14;
    localparam int ROUND_SHIFT = 44;

    localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Half an output LSB in Q.58, added before the final shift.
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (ROUND_SHIFT - 1);

    // Saturation limits, plus and minus one in Q1.14.
    localparam logic signed [CELL_W-1:0] CELL_MAX = 16'sd16384;
    localparam logic signed [CELL_W-1:0] CELL_MIN = -16'sd16384;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axis;

    // Sideband that rides along the CORDIC chain.
    typedef struct packed {
        logic  flip;
        t_axis axis;
    } t_side;

    // Exact matrix entries before rounding, rounding constant already added.
    typedef struct packed {
        logic signed [SW-1:0] s00;
        logic signed [SW-1:0] s01;
        logic signed [SW-1:0] s02;
        logic signed [SW-1:0] s10;
        logic signed [SW-1:0] s11;
        logic signed [SW-1:0] s12;
        logic signed [SW-1:0] s20;
        logic signed [SW-1:0] s21;
        logic signed [SW-1:0] s22;
    } t_sums;

    // atan(2^-idx) in Q.30, truncated.
    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:       v = 34'sh3243F6A8;
            1:       v = 34'sh1DAC6705;
            2:       v = 34'sh0FADBAFC;
            3:       v = 34'sh07F56EA6;
            4:       v = 34'sh03FEAB76;
            5:       v = 34'sh01FFD55B;
            6:       v = 34'sh00FFFAAA;
            7:       v = 34'sh007FFF55;
            8:       v = 34'sh003FFFEA;
            9:       v = 34'sh001FFFFD;
            10:      v = 34'sh000FFFFF;
            11:      v = 34'sh0007FFFF;
            12:      v = 34'sh0003FFFF;
            13:      v = 34'sh0001FFFF;
            14:      v = 34'sh0000FFFF;
            15:      v = 34'sh00007FFF;
            16:      v = 34'sh00003FFF;
            17:      v = 34'sh00001FFF;
            18:      v = 34'sh00000FFF;
            19:      v = 34'sh000007FF;
            20:      v = 34'sh000003FF;
            21:      v = 34'sh000001FF;
            22:      v = 34'sh000000FF;
            23:      v = 34'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/aar_cordic_stage.sv
// ----------------------------------------------------------------------------
// aar_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [aar_pkg::CW-1:0] i_x,
    input  logic signed [aar_pkg::CW-1:0] i_y,
    input  logic signed [aar_pkg::CW-1:0] i_z,
    input  aar_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic signed [aar_pkg::CW-1:0] o_x,
    output logic signed [aar_pkg::CW-1:0] o_y,
    output logic signed [aar_pkg::CW-1:0] o_z,
    output aar_pkg::t_side                o_side
);

    localparam int CW = aar_pkg::CW;
    localparam logic signed [CW-1:0] ATAN = aar_pkg::atan_q30(SHIFT);

    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    aar_pkg::t_side       r_side;
    logic                 r_valid;

    // Rotate towards zero residual angle; the shifts floor like the maths.
    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ATAN;
        end
    end

    // Valid bit of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

>>> rtl/aar_cordic.sv
// ----------------------------------------------------------------------------
// aar_cordic
// Folds the angle into the CORDIC range, runs the iteration chain and forms
// cosine, sine and one minus cosine in Q.30.
// ----------------------------------------------------------------------------
`default_nettype none

`include "axis_angle_rotation_matrix_macros.svh"

module aar_cordic #(
    parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  aar_pkg::t_axis                     i_axis,
    input  logic signed [aar_pkg::ANGLE_W-1:0] i_angle,
    output logic                               o_valid,
    output aar_pkg::t_axis                     o_axis,
    output logic signed [aar_pkg::CW-1:0]      o_c,
    output logic signed [aar_pkg::CW-1:0]      o_s,
    output logic signed [aar_pkg::CW-1:0]      o_t
);

    localparam int CW  = aar_pkg::CW;
    // Iterations beyond the tabulated arctangents are not run.
    localparam int RUN = (CORDIC_STAGES < aar_pkg::ATAN_LEN) ?
                         CORDIC_STAGES : aar_pkg::ATAN_LEN;
    localparam logic signed [CW-1:0] NEG_HALF_PI = -aar_pkg::Q30_HALF_PI;

    logic signed [CW-1:0] w_angle;
    logic signed [CW-1:0] n_z0;
    aar_pkg::t_side       n_side0;
    logic signed [CW-1:0] r_z0;
    aar_pkg::t_side       r_side0;
    logic                 r_valid0;

    logic signed [CW-1:0] w_x [RUN+1];
    logic signed [CW-1:0] w_y [RUN+1];
    logic signed [CW-1:0] w_z [RUN+1];
    aar_pkg::t_side       w_side [RUN+1];
    logic [RUN:0]         w_valid;

    logic signed [CW-1:0] n_c;
    logic signed [CW-1:0] n_s;
    logic signed [CW-1:0] n_t;
    logic signed [CW-1:0] r_c;
    logic signed [CW-1:0] r_s;
    logic signed [CW-1:0] r_t;
    aar_pkg::t_axis       r_axis;
    logic                 r_valid;

    // Widen the angle to Q.30 and fold it by pi when it lies beyond pi/2.
    assign w_angle = CW'(i_angle) <<< aar_pkg::ANGLE_SHIFT;

    always_comb begin
        n_side0.axis = i_axis;
        if (w_angle > aar_pkg::Q30_HALF_PI) begin
            n_z0         = w_angle - aar_pkg::Q30_PI;
            n_side0.flip = 1'b1;
        end else if (w_angle < NEG_HALF_PI) begin
            n_z0         = w_angle + aar_pkg::Q30_PI;
            n_side0.flip = 1'b1;
        end else begin
            n_z0         = w_angle;
            n_side0.flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (i_en) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0    <= n_z0;
            r_side0 <= n_side0;
        end
    end

    // The chain starts from the gain-compensated unit vector.
    assign w_x[0]    = aar_pkg::CORDIC_GAIN;
    assign w_y[0]    = '0;
    assign w_z[0]    = r_z0;
    assign w_side[0] = r_side0;
    assign w_valid[0] = r_valid0;

    for (genvar k = 0; k < RUN; k++) begin : g_stage
        aar_cordic_stage #(
            .SHIFT (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // Undo the fold by negating, and form t = 1 - c in the same step.
    always_comb begin
        if (w_side[RUN].flip) begin
            n_c = -w_x[RUN];
            n_s = -w_y[RUN];
            n_t = aar_pkg::Q30_ONE + w_x[RUN];
        end else begin
            n_c = w_x[RUN];
            n_s = w_y[RUN];
            n_t = aar_pkg::Q30_ONE - w_x[RUN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= w_valid[RUN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c    <= n_c;
            r_s    <= n_s;
            r_t    <= n_t;
            r_axis <= w_side[RUN].axis;
        end
    end

    assign o_valid = r_valid;
    assign o_axis  = r_axis;
    assign o_c     = r_c;
    assign o_s     = r_s;
    assign o_t     = r_t;

    // The folded angle must lie within the CORDIC convergence range.
    `AAR_ASSERT_NOW(a_fold_range, i_clk, i_rst_n, r_valid0,
                    (r_z0 <= aar_pkg::Q30_HALF_PI) && (r_z0 >= NEG_HALF_PI),
                    "folded angle outside plus or minus pi/2")
    // One minus cosine must agree with the cosine it travels with.
    `AAR_ASSERT_NOW(a_t_matches_c, i_clk, i_rst_n, r_valid,
                    (CW'(r_t + r_c) == aar_pkg::Q30_ONE), "t and c out of step")

endmodule

`default_nettype wire

>>> rtl/aar_matrix.sv
// ----------------------------------------------------------------------------
// aar_matrix
// Three register stages that form the exact Rodrigues entries in Q.58 from
// the axis, c, s and t, with the rounding half already added.
// ----------------------------------------------------------------------------
`default_nettype none

module aar_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  aar_pkg::t_axis                i_axis,
    input  logic signed [aar_pkg::CW-1:0] i_c,
    input  logic signed [aar_pkg::CW-1:0] i_s,
    input  logic signed [aar_pkg::CW-1:0] i_t,
    output logic                          o_valid,
    output aar_pkg::t_sums                o_sum
);

    localparam int CW = aar_pkg::CW;
    localparam int PW = aar_pkg::PW;
    localparam int SW = aar_pkg::SW;
    localparam logic signed [SW-1:0] RND = aar_pkg::ROUND_HALF;

    // First stage: axis times t and axis times s.
    logic signed [PW-1:0] r_a_xt;
    logic signed [PW-1:0] r_a_yt;
    logic signed [PW-1:0] r_a_zt;
    logic signed [PW-1:0] r_a_xs;
    logic signed [PW-1:0] r_a_ys;
    logic signed [PW-1:0] r_a_zs;
    logic signed [CW-1:0] r_a_c;
    aar_pkg::t_axis       r_a_axis;
    logic                 r_a_valid;

    // Second stage: the six distinct axis-axis-t products.
    logic signed [SW-1:0] r_b_xxt;
    logic signed [SW-1:0] r_b_xyt;
    logic signed [SW-1:0] r_b_xzt;
    logic signed [SW-1:0] r_b_yyt;
    logic signed [SW-1:0] r_b_yzt;
    logic signed [SW-1:0] r_b_zzt;
    logic signed [PW-1:0] r_b_xs;
    logic signed [PW-1:0] r_b_ys;
    logic signed [PW-1:0] r_b_zs;
    logic signed [CW-1:0] r_b_c;
    logic                 r_b_valid;

    // Third stage: the nine sums.
    logic signed [SW-1:0] w_cq;
    logic signed [SW-1:0] w_xs;
    logic signed [SW-1:0] w_ys;
    logic signed [SW-1:0] w_zs;
    aar_pkg::t_sums       n_sum;
    aar_pkg::t_sums       r_sum;
    logic                 r_c_valid;

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Stage one multiplies.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_xt   <= PW'(i_axis.x) * PW'(i_t);
            r_a_yt   <= PW'(i_axis.y) * PW'(i_t);
            r_a_zt   <= PW'(i_axis.z) * PW'(i_t);
            r_a_xs   <= PW'(i_axis.x) * PW'(i_s);
            r_a_ys   <= PW'(i_axis.y) * PW'(i_s);
            r_a_zs   <= PW'(i_axis.z) * PW'(i_s);
            r_a_c    <= i_c;
            r_a_axis <= i_axis;
        end
    end

    // Stage two multiplies; the matrix is symmetric in its t part.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_xxt <= SW'(r_a_xt) * SW'(r_a_axis.x);
            r_b_xyt <= SW'(r_a_xt) * SW'(r_a_axis.y);
            r_b_xzt <= SW'(r_a_xt) * SW'(r_a_axis.z);
            r_b_yyt <= SW'(r_a_yt) * SW'(r_a_axis.y);
            r_b_yzt <= SW'(r_a_yt) * SW'(r_a_axis.z);
            r_b_zzt <= SW'(r_a_zt) * SW'(r_a_axis.z);
            r_b_xs  <= r_a_xs;
            r_b_ys  <= r_a_ys;
            r_b_zs  <= r_a_zs;
            r_b_c   <= r_a_c;
        end
    end

    // Bring c and the sine terms to Q.58 and add up each entry.
    assign w_cq = SW'(r_b_c) <<< aar_pkg::C_SHIFT;
    assign w_xs = SW'(r_b_xs) <<< aar_pkg::S_SHIFT;
    assign w_ys = SW'(r_b_ys) <<< aar_pkg::S_SHIFT;
    assign w_zs = SW'(r_b_zs) <<< aar_pkg::S_SHIFT;

    always_comb begin
        n_sum.s00 = w_cq + r_b_xxt + RND;
        n_sum.s01 = r_b_xyt - w_zs + RND;
        n_sum.s02 = r_b_xzt + w_ys + RND;
        n_sum.s10 = r_b_xyt + w_zs + RND;
        n_sum.s11 = w_cq + r_b_yyt + RND;
        n_sum.s12 = r_b_yzt - w_xs + RND;
        n_sum.s20 = r_b_xzt - w_ys + RND;
        n_sum.s21 = r_b_yzt + w_xs + RND;
        n_sum.s22 = w_cq + r_b_zzt + RND;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_c_valid;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

>>> rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis-angle to Rodrigues rotation matrix: CORDIC cosine and sine, products,
// rounding to Q1.14 and saturation, with an output register and skid stage.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while o_stall is low and gives one matrix per beat, in order.
// An accepted input beat passes through the angle fold register, the chain of
// CORDIC iterations (CORDIC_STAGES, capped at 24), the sign fix and t register,
// the product and sum pipeline and rounding into the output register.
// The latency grows with the chain of registered CORDIC iterations. A stall on
// the result side is absorbed by a one-beat skid stage, so o_stall is taken
// straight from a register and the pipeline holds only while that stage is
// full. The block keeps no state between beats.
`default_nettype none

`include "axis_angle_rotation_matrix_macros.svh"

module axis_angle_rotation_matrix #(
    parameter int CORDIC_STAGES = aar_pkg::CORDIC_STAGES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [aar_pkg::AXIS_W-1:0]   i_axis_x,
    input  logic signed [aar_pkg::AXIS_W-1:0]   i_axis_y,
    input  logic signed [aar_pkg::AXIS_W-1:0]   i_axis_z,
    input  logic signed [aar_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_0_0,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_0_1,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_0_2,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_1_0,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_1_1,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_1_2,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_2_0,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_2_1,
    output logic signed [aar_pkg::CELL_W-1:0]   o_cell_2_2
);

    localparam int CW    = aar_pkg::CW;
    localparam int SW    = aar_pkg::SW;
    localparam int CELLW = aar_pkg::CELL_W;
    localparam int SHW   = SW - aar_pkg::ROUND_SHIFT;
    localparam logic signed [SHW-1:0] SAT_HI = SHW'(aar_pkg::CELL_MAX);
    localparam logic signed [SHW-1:0] SAT_LO = SHW'(aar_pkg::CELL_MIN);

    typedef struct packed {
        logic signed [CELLW-1:0] c00;
        logic signed [CELLW-1:0] c01;
        logic signed [CELLW-1:0] c02;
        logic signed [CELLW-1:0] c10;
        logic signed [CELLW-1:0] c11;
        logic signed [CELLW-1:0] c12;
        logic signed [CELLW-1:0] c20;
        logic signed [CELLW-1:0] c21;
        logic signed [CELLW-1:0] c22;
    } t_cells;

    logic                 w_en;
    aar_pkg::t_axis       w_axis;
    logic                 w_cs_valid;
    aar_pkg::t_axis       w_cs_axis;
    logic signed [CW-1:0] w_c;
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] w_t;
    logic                 w_sum_valid;
    aar_pkg::t_sums       w_sum;
    t_cells               n_cells;
    t_cells               r_out;
    t_cells               r_skid;
    logic                 r_out_valid;
    logic                 r_skid_valid;

    // Drop the rounded-in half LSB bits and clamp to plus or minus one.
    function automatic logic signed [CELLW-1:0] sat_q14(input logic signed [SW-1:0] v);
        logic signed [SHW-1:0] q;
        q = $signed(v[SW-1:aar_pkg::ROUND_SHIFT]);
        if (q > SAT_HI) begin
            return aar_pkg::CELL_MAX;
        end else if (q < SAT_LO) begin
            return aar_pkg::CELL_MIN;
        end else begin
            return CELLW'(q);
        end
    endfunction

    // The whole pipeline advances unless the skid stage holds a beat.
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    assign w_axis.x = i_axis_x;
    assign w_axis.y = i_axis_y;
    assign w_axis.z = i_axis_z;

    aar_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_axis  (w_axis),
        .i_angle (i_angle),
        .o_valid (w_cs_valid),
        .o_axis  (w_cs_axis),
        .o_c     (w_c),
        .o_s     (w_s),
        .o_t     (w_t)
    );

    aar_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cs_valid),
        .i_axis  (w_cs_axis),
        .i_c     (w_c),
        .i_s     (w_s),
        .i_t     (w_t),
        .o_valid (w_sum_valid),
        .o_sum   (w_sum)
    );

    // Rounding and saturation of the nine entries.
    always_comb begin
        n_cells.c00 = sat_q14(w_sum.s00);
        n_cells.c01 = sat_q14(w_sum.s01);
        n_cells.c02 = sat_q14(w_sum.s02);
        n_cells.c10 = sat_q14(w_sum.s10);
        n_cells.c11 = sat_q14(w_sum.s11);
        n_cells.c12 = sat_q14(w_sum.s12);
        n_cells.c20 = sat_q14(w_sum.s20);
        n_cells.c21 = sat_q14(w_sum.s21);
        n_cells.c22 = sat_q14(w_sum.s22);
    end

    // Output register and skid stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_sum_valid) begin
            if (r_out_valid && i_stall) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register and skid stage data.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (w_sum_valid) begin
            if (r_out_valid && i_stall) begin
                r_skid <= n_cells;
            end else begin
                r_out <= n_cells;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_cell_0_0 = r_out.c00;
    assign o_cell_0_1 = r_out.c01;
    assign o_cell_0_2 = r_out.c02;
    assign o_cell_1_0 = r_out.c10;
    assign o_cell_1_1 = r_out.c11;
    assign o_cell_1_2 = r_out.c12;
    assign o_cell_2_0 = r_out.c20;
    assign o_cell_2_1 = r_out.c21;
    assign o_cell_2_2 = r_out.c22;

    // A beat in the skid stage always has one ahead of it in the output register.
    `AAR_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
                    "skid beat without output beat")
    // A taken output drains the skid stage into the output register.
    `AAR_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_stall,
                     !r_skid_valid && r_out_valid, "skid stage failed to drain")
    // Saturation keeps every entry within plus or minus one; entries c00 and c12 are checked.
    `AAR_ASSERT_NOW(a_cell_range, i_clk, i_rst_n, r_out_valid,
                    (r_out.c00 <= aar_pkg::CELL_MAX) && (r_out.c00 >= aar_pkg::CELL_MIN) &&
                    (r_out.c12 <= aar_pkg::CELL_MAX) && (r_out.c12 >= aar_pkg::CELL_MIN),
                    "matrix entry beyond plus or minus one")

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: axis-angle rotation matrix testbench
// Drives axis and angle beats into the block with random idle gaps and
// output stalls, predicts each Rodrigues matrix with an independent CORDIC
// and fixed-point model, and compares every result cell by cell in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int STAGES      = 16;
    localparam int RUN_BEATS   = 1750;
    localparam int CALM_BEATS  = 150;
    localparam int DRAIN_WAIT  = 60;
    localparam int CYCLE_LIMIT = 250000;

    localparam int AW = aar_pkg::AXIS_W;
    localparam int GW = aar_pkg::ANGLE_W;
    localparam int MW = aar_pkg::CELL_W;

    // Angle codes in Q3.13 around the fold points, and a unit axis in Q1.14.
    localparam logic signed [GW-1:0] ANG_PI      = 16'sd25736;
    localparam logic signed [GW-1:0] ANG_HALF_PI = 16'sd12868;
    localparam logic signed [AW-1:0] UNIT        = 16'sd16384;

    // Fixed-point constants of the cosine and sine datapath, all Q.30.
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam int     ATAN_ROWS   = 24;
    localparam longint ATAN_Q30 [ATAN_ROWS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Nine cells, index 3*row + column.
    typedef logic [8:0][MW-1:0] t_matrix;

    // Predicts the matrix of each accepted beat and checks results in order.
    class matrix_scoreboard;
        t_matrix     awaited[$];
        int unsigned mismatches;
        string       cell_names [9] = '{"cell_0_0", "cell_0_1", "cell_0_2",
                                        "cell_1_0", "cell_1_1", "cell_1_2",
                                        "cell_2_0", "cell_2_1", "cell_2_2"};

        function void cos_sin_of(input longint angle, output longint c, output longint s);
            longint vx;
            longint vy;
            longint rest;
            longint dx;
            longint dy;
            bit     flip;
            flip = 1'b0;
            // Fold the angle by pi into the range the iterations converge on.
            if (angle > HALF_PI_Q30) begin
                angle = angle - PI_Q30;
                flip  = 1'b1;
            end else if (angle < -HALF_PI_Q30) begin
                angle = angle + PI_Q30;
                flip  = 1'b1;
            end
            vx   = GAIN_Q30;
            vy   = 0;
            rest = angle;
            for (int i = 0; i < STAGES && i < ATAN_ROWS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (rest >= 0) begin
                    vx   = vx - dx;
                    vy   = vy + dy;
                    rest = rest - ATAN_Q30[i];
                end else begin
                    vx   = vx + dx;
                    vy   = vy - dy;
                    rest = rest + ATAN_Q30[i];
                end
            end
            c = flip ? -vx : vx;
            s = flip ? -vy : vy;
        endfunction

        // Round an exact Q.58 sum to Q1.14, half up, and clamp to plus or minus one.
        function logic [MW-1:0] round_to_cell(input longint v);
            longint r;
            r = (v + (longint'(1) <<< 43)) >>> 44;
            if (r > 16384)
                r = 16384;
            if (r < -16384)
                r = -16384;
            return r[MW-1:0];
        endfunction

        function t_matrix rotation_of(input logic signed [AW-1:0] ax,
                                      input logic signed [AW-1:0] ay,
                                      input logic signed [AW-1:0] az,
                                      input logic signed [GW-1:0] ang);
            longint  x;
            longint  y;
            longint  z;
            longint  c;
            longint  s;
            longint  t;
            longint  cq;
            longint  xs;
            longint  ys;
            longint  zs;
            t_matrix m;
            x = ax;
            y = ay;
            z = az;
            cos_sin_of(longint'(ang) * 131072, c, s);
            t  = ONE_Q30 - c;
            cq = c * (longint'(1) <<< 28);
            xs = x * s * 16384;
            ys = y * s * 16384;
            zs = z * s * 16384;
            m[0] = round_to_cell(cq + x * x * t);
            m[1] = round_to_cell(x * y * t - zs);
            m[2] = round_to_cell(x * z * t + ys);
            m[3] = round_to_cell(y * x * t + zs);
            m[4] = round_to_cell(cq + y * y * t);
            m[5] = round_to_cell(y * z * t - xs);
            m[6] = round_to_cell(z * x * t - ys);
            m[7] = round_to_cell(z * y * t + xs);
            m[8] = round_to_cell(cq + z * z * t);
            return m;
        endfunction

        function void note_beat(input logic signed [AW-1:0] ax,
                                input logic signed [AW-1:0] ay,
                                input logic signed [AW-1:0] az,
                                input logic signed [GW-1:0] ang);
            awaited.push_back(rotation_of(ax, ay, az, ang));
        endfunction

        function void check_matrix(input t_matrix got);
            t_matrix want;
            if (awaited.size() == 0) begin
                $error("result beat arrived with no matrix awaited");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            for (int i = 0; i < 9; i++) begin
                if (got[i] !== want[i]) begin
                    $error("%s: expected %0d, actual %0d", cell_names[i],
                           $signed(want[i]), $signed(got[i]));
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  i_stall   = 1'b0;
    logic signed [AW-1:0]  i_axis_x  = '0;
    logic signed [AW-1:0]  i_axis_y  = '0;
    logic signed [AW-1:0]  i_axis_z  = '0;
    logic signed [GW-1:0]  i_angle   = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic signed [MW-1:0]  o_cell_0_0, o_cell_0_1, o_cell_0_2;
    logic signed [MW-1:0]  o_cell_1_0, o_cell_1_1, o_cell_1_2;
    logic signed [MW-1:0]  o_cell_2_0, o_cell_2_1, o_cell_2_2;

    matrix_scoreboard rotations = new();

    // Idle odds in percent per beat, shared by both sides; zero means none.
    int unsigned idle_pct   = 0;
    int unsigned stall_left = 0;
    int unsigned cycles     = 0;

    axis_angle_rotation_matrix #(
        .CORDIC_STAGES (STAGES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_axis_x   (i_axis_x),
        .i_axis_y   (i_axis_y),
        .i_axis_z   (i_axis_z),
        .i_angle    (i_angle),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cell_0_0 (o_cell_0_0),
        .o_cell_0_1 (o_cell_0_1),
        .o_cell_0_2 (o_cell_0_2),
        .o_cell_1_0 (o_cell_1_0),
        .o_cell_1_1 (o_cell_1_1),
        .o_cell_1_2 (o_cell_1_2),
        .o_cell_2_0 (o_cell_2_0),
        .o_cell_2_1 (o_cell_2_1),
        .o_cell_2_2 (o_cell_2_2)
    );

    always #2 i_clk = ~i_clk;

    // Both handshakes are sampled at the edge, before any update of that step.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            rotations.note_beat(i_axis_x, i_axis_y, i_axis_z, i_angle);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            rotations.check_matrix({o_cell_2_2, o_cell_2_1, o_cell_2_0,
                                    o_cell_1_2, o_cell_1_1, o_cell_1_0,
                                    o_cell_0_2, o_cell_0_1, o_cell_0_0});
        end
    end

    // Output stalls come in bursts whose length is drawn at random when each burst starts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            i_stall    <= 1'b0;
        end
    end

    // Hang guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One beat, after an optional idle burst; valid stays high between beats.
    task automatic send_beat(input logic signed [AW-1:0] ax,
                             input logic signed [AW-1:0] ay,
                             input logic signed [AW-1:0] az,
                             input logic signed [GW-1:0] ang);
        int unsigned gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_axis_x <= ax;
        i_axis_y <= ay;
        i_axis_z <= az;
        i_angle  <= ang;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // A random axis of unit length, rounded to Q1.14.
    task automatic unit_axis(output logic signed [AW-1:0] ax,
                             output logic signed [AW-1:0] ay,
                             output logic signed [AW-1:0] az);
        real ux;
        real uy;
        real uz;
        real len;
        do begin
            ux  = real'(int'($urandom_range(0, 2000)) - 1000);
            uy  = real'(int'($urandom_range(0, 2000)) - 1000);
            uz  = real'(int'($urandom_range(0, 2000)) - 1000);
            len = $sqrt(ux * ux + uy * uy + uz * uz);
        end while (len < 1.0);
        ax = AW'(int'(ux * 16384.0 / len));
        ay = AW'(int'(uy * 16384.0 / len));
        az = AW'(int'(uz * 16384.0 / len));
    endtask

    initial begin
        logic signed [AW-1:0] ax;
        logic signed [AW-1:0] ay;
        logic signed [AW-1:0] az;
        logic signed [GW-1:0] ang;
        int unsigned          pick;

        repeat (12) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        idle_pct <= 20;
        @(posedge i_clk);

        // Directed beats: axis extremes, the fold points, codes beyond pi,
        // zero and oversized axes that saturate.
        send_beat(UNIT, 16'sd0, 16'sd0, 16'sd0);
        send_beat(UNIT, 16'sd0, 16'sd0, ANG_PI);
        send_beat(UNIT, 16'sd0, 16'sd0, -ANG_PI);
        send_beat(16'sd0, UNIT, 16'sd0, ANG_HALF_PI);
        send_beat(16'sd0, 16'sd0, UNIT, -ANG_HALF_PI);
        send_beat(-UNIT, 16'sd0, 16'sd0, ANG_HALF_PI + 16'sd1);
        send_beat(16'sd0, -UNIT, 16'sd0, -ANG_HALF_PI - 16'sd1);
        send_beat(16'sd0, 16'sd0, -UNIT, ANG_HALF_PI - 16'sd1);
        send_beat(16'sd0, 16'sd0, -UNIT, 16'sh7FFF);
        send_beat(UNIT, UNIT, UNIT, 16'sh8000);
        send_beat(-UNIT, -UNIT, -UNIT, 16'sd8000);
        send_beat(16'sh7FFF, 16'sh8000, 16'sd0, ANG_PI);
        send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd3000);
        send_beat(16'sh8000, 16'sh8000, 16'sh8000, -ANG_PI);
        send_beat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, ANG_HALF_PI - 16'sd1);
        send_beat(16'sd9459, 16'sd9459, 16'sd9459, 16'sd16384);
        send_beat(16'sd9459, -16'sd9459, 16'sd9459, -16'sd1);
        send_beat(16'sd11585, 16'sd11585, 16'sd0, 16'sd1);
        send_beat(16'sd0, 16'sd11585, -16'sd11585, -16'sd20000);
        send_beat(-16'sd11585, 16'sd0, 16'sd11585, ANG_PI + 16'sd1);

        // Random beats: mostly unit axes over minus pi to pi, the rest
        // axis-aligned or raw codes over the full field range.
        for (int n = 0; n < RUN_BEATS; n++) begin
            if (n == RUN_BEATS - CALM_BEATS)
                idle_pct <= 0;
            else if (n % 250 == 0 && n < RUN_BEATS - CALM_BEATS)
                idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                unit_axis(ax, ay, az);
                ang = GW'(int'($urandom_range(0, 2 * 25736)) - 25736);
            end else if (pick < 75) begin
                ax  = '0;
                ay  = '0;
                az  = '0;
                case ($urandom_range(0, 2))
                    0:       ax = $urandom_range(0, 1) ? UNIT : -UNIT;
                    1:       ay = $urandom_range(0, 1) ? UNIT : -UNIT;
                    default: az = $urandom_range(0, 1) ? UNIT : -UNIT;
                endcase
                ang = GW'($urandom);
            end else begin
                ax  = AW'($urandom);
                ay  = AW'($urandom);
                az  = AW'($urandom);
                ang = GW'($urandom);
            end
            send_beat(ax, ay, az, ang);
        end
        i_valid <= 1'b0;

        // Drain the pipeline, then allow for anything spurious behind it.
        while (rotations.awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (rotations.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
